/* design/tls_pkg.sv */
// Shared types and constants for the triangle layer slicer.
// Used by the front end, the queue, the back end and the top level.
// No dependencies.
`default_nettype none

package tls_pkg;

	localparam int LAYER_W = 12;
	localparam int COORD_W = 32;
	localparam int MAG_W = 33;
	localparam int DIV_BITS = 34;
	localparam int NUM_W = 2 * MAG_W;
	localparam int LANES = 4;

	// Configuration register indexes (word address bits).
	localparam logic [1:0] REG_Y_MIN = 2'd0;
	localparam logic [1:0] REG_LAYER_STEP = 2'd1;
	localparam logic [1:0] REG_TOLERANCE = 2'd2;

	typedef enum logic {
		MODE_SEG,
		MODE_EDGES
	} mode_t;

	typedef struct packed {
		logic signed [31:0] y_min;
		logic [30:0] layer_step;
		logic [15:0] tol;
	} cfg_t;

	typedef struct packed {
		logic [11:0] layer_index;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
	} facet_t;

	typedef struct packed {
		logic [11:0] out_layer;
		logic segment_kind;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic last;
	} seg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	// One interpolated coordinate: magnitude of the coordinate delta, sign, base.
	typedef struct packed {
		logic [MAG_W-1:0] mc;
		logic neg;
		logic signed [31:0] qc;
	} lane_t;

	// One edge crossing: height magnitudes and the x and z lanes.
	typedef struct packed {
		logic [MAG_W-1:0] mh;
		logic [MAG_W-1:0] my;
		lane_t x;
		lane_t z;
	} slot_t;

	// Control part of an item, carried through the whole back end.
	typedef struct packed {
		logic [11:0] layer;
		mode_t mode;
		logic start_cross;
		logic end_cross;
		logic signed [31:0] h;
		point_t [2:0] pt;
	} ctl_t;

	typedef struct packed {
		ctl_t ctl;
		slot_t [1:0] sl;
	} q_item_t;

	// Per lane data that the divider pipeline carries along.
	typedef struct packed {
		logic neg;
		logic signed [31:0] qc;
		logic [MAG_W-1:0] den;
	} lc_t;

endpackage

`default_nettype wire

/* design/tls_front.sv */
// Front end: computes the layer height, classifies the triangle and prepares
// the crossing operands. Depends on tls_pkg.
`default_nettype none

module tls_front import tls_pkg::*; #(
	parameter int LAYER_INDEX_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire facet_t facet,
	input wire logic facet_valid,
	output logic facet_ready,
	output q_item_t push_item,
	output logic push_valid,
	input wire logic push_ready
);

	localparam logic [LAYER_W-1:0] LAYER_MASK = (LAYER_INDEX_BITS >= LAYER_W) ? '1 :
		LAYER_W'((1 << LAYER_INDEX_BITS) - 1);

	logic valid_s1, valid_s2;
	facet_t facet_m;
	facet_t facet_s1, facet_s2;
	logic [42:0] prod_s1;
	logic signed [31:0] h_s2;
	logic keep;
	logic adv;
	logic signed [44:0] sum;
	logic signed [31:0] h_sat;

	function automatic logic [MAG_W-1:0] abs33(input logic signed [MAG_W-1:0] v);
		return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	assign adv = !(valid_s2 && keep) || push_ready;
	assign facet_ready = adv;
	assign push_valid = valid_s2 && keep;

	// Incoming item with the layer index cut to the configured width.
	always_comb begin
		facet_m = facet;
		facet_m.layer_index = facet.layer_index & LAYER_MASK;
	end

	// Layer height: add the offset and saturate to 32 bits.
	always_comb begin
		sum = $signed({{13{cfg.y_min[31]}}, cfg.y_min}) + $signed({2'b00, prod_s1});
		if (sum > 45'sd2147483647) begin
			h_sat = 32'sh7fffffff;
		end else if (sum < -45'sd2147483648) begin
			h_sat = 32'sh80000000;
		end else begin
			h_sat = sum[31:0];
		end
	end

	// Two stages: step product, then height.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= facet_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			facet_s1 <= facet_m;
			prod_s1 <= 43'(cfg.layer_step) * 43'(facet_m.layer_index);
			facet_s2 <= facet_s1;
			h_s2 <= h_sat;
		end
	end

	// Classification and operand setup.
	point_t v [3];
	logic [2:0] gt, lt, eq, on;
	logic [2:0] cv;
	slot_t ed [3];
	logic [1:0] ncross, non;
	logic [1:0] s_idx, f_idx, l_idx, e_idx;
	logic signed [MAG_W-1:0] dh, dy, dcx, dcz, dv;
	int p, q;

	always_comb begin
		v[0] = '{facet_s2.a_x, facet_s2.a_y, facet_s2.a_z};
		v[1] = '{facet_s2.b_x, facet_s2.b_y, facet_s2.b_z};
		v[2] = '{facet_s2.c_x, facet_s2.c_y, facet_s2.c_z};
		for (int i = 0; i < 3; i++) begin
			gt[i] = v[i].y > h_s2;
			lt[i] = v[i].y < h_s2;
			eq[i] = v[i].y == h_s2;
			dv = MAG_W'(v[i].y) - MAG_W'(h_s2);
			on[i] = abs33(dv) < MAG_W'(cfg.tol);
		end
		// Edges in order ab, ac, bc.
		for (int e = 0; e < 3; e++) begin
			p = (e == 2) ? 1 : 0;
			q = (e == 0) ? 1 : 2;
			cv[e] = (v[p] != v[q]) && !(gt[p] && gt[q]) && !(lt[p] && lt[q]) &&
				(v[p].y != v[q].y);
			dh = MAG_W'(h_s2) - MAG_W'(v[q].y);
			dy = MAG_W'(v[p].y) - MAG_W'(v[q].y);
			dcx = MAG_W'(v[p].x) - MAG_W'(v[q].x);
			dcz = MAG_W'(v[p].z) - MAG_W'(v[q].z);
			ed[e].mh = abs33(dh);
			ed[e].my = abs33(dy);
			ed[e].x.mc = abs33(dcx);
			ed[e].x.neg = dcx[MAG_W-1] ^ dh[MAG_W-1] ^ dy[MAG_W-1];
			ed[e].x.qc = v[q].x;
			ed[e].z.mc = abs33(dcz);
			ed[e].z.neg = dcz[MAG_W-1] ^ dh[MAG_W-1] ^ dy[MAG_W-1];
			ed[e].z.qc = v[q].z;
		end
		ncross = 2'(cv[0]) + 2'(cv[1]) + 2'(cv[2]);
		non = 2'(on[0]) + 2'(on[1]) + 2'(on[2]);
		s_idx = on[0] ? 2'd0 : (on[1] ? 2'd1 : 2'd2);
		e_idx = 2'd2 - s_idx;
		f_idx = on[0] ? 2'd0 : 2'd1;
		l_idx = on[2] ? 2'd2 : 2'd1;

		push_item.ctl.layer = facet_s2.layer_index;
		push_item.ctl.mode = MODE_SEG;
		push_item.ctl.start_cross = 1'b0;
		push_item.ctl.end_cross = 1'b0;
		push_item.ctl.h = h_s2;
		push_item.ctl.pt[0] = v[0];
		push_item.ctl.pt[1] = v[1];
		push_item.ctl.pt[2] = v[2];
		push_item.sl[0] = ed[0];
		push_item.sl[1] = ed[1];
		keep = 1'b0;

		if ((gt == 3'b111) || (lt == 3'b111)) begin
			keep = 1'b0;
		end else if (eq == 3'b000) begin
			// Plain cut: the first two crossing edges.
			keep = (ncross == 2'd2);
			push_item.ctl.start_cross = 1'b1;
			push_item.ctl.end_cross = 1'b1;
			push_item.sl[0] = cv[0] ? ed[0] : ed[1];
			push_item.sl[1] = cv[2] ? ed[2] : ed[1];
		end else begin
			case (non)
				2'd1: begin
					// Vertex on the layer plus crossing of the opposite edge.
					keep = cv[e_idx];
					push_item.ctl.end_cross = 1'b1;
					push_item.ctl.pt[0] = v[s_idx];
					push_item.sl[1] = ed[e_idx];
				end
				2'd2: begin
					keep = 1'b1;
					push_item.ctl.pt[0] = v[f_idx];
					push_item.ctl.pt[1] = v[l_idx];
				end
				2'd3: begin
					keep = 1'b1;
					push_item.ctl.mode = MODE_EDGES;
				end
				default: begin
					keep = 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/tls_queue.sv */
// Two-entry item queue between the front end and the back end.
// Depends on tls_pkg.
`default_nettype none

module tls_queue import tls_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire q_item_t push_item,
	input wire logic push_valid,
	output logic push_ready,
	output q_item_t pop_item,
	output logic pop_valid,
	input wire logic pop_ready
);

	q_item_t mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid = count_q != 2'd0;
	assign pop_item = mem_q[rptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop) rptr_q <= !rptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push_item;
	end

endmodule

`default_nettype wire

/* design/tls_back.sv */
// Back end: multiplies, divides in a bit-per-stage pipeline and emits the
// segments of each item. Depends on tls_pkg.
`default_nettype none

module tls_back import tls_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire q_item_t pop_item,
	input wire logic pop_valid,
	output logic pop_ready,
	output seg_t seg,
	output logic seg_valid,
	input wire logic seg_ready
);

	logic adv, last_now;

	logic valid_s1, valid_s2;
	ctl_t ctl_s1, ctl_s2;
	logic [NUM_W-1:0] prod_s1 [LANES];
	lc_t lc_s1 [LANES];
	lc_t lc_s2 [LANES];
	logic [MAG_W-1:0] rem_s2 [LANES];
	logic [DIV_BITS-1:0] low_s2 [LANES];

	logic [DIV_BITS-1:0] valid_sd;
	ctl_t ctl_sd [DIV_BITS];
	lc_t lc_sd [DIV_BITS][LANES];
	logic [MAG_W-1:0] rem_sd [DIV_BITS][LANES];
	logic [DIV_BITS-1:0] low_sd [DIV_BITS][LANES];
	logic [MAG_W-1:0] rem_nx [DIV_BITS][LANES];
	logic [DIV_BITS-1:0] low_nx [DIV_BITS][LANES];

	logic out_valid_q;
	ctl_t out_ctl_q;
	logic signed [31:0] out_cr_q [LANES];
	logic [1:0] out_k_q;

	lane_t ln [LANES];
	logic [MAG_W-1:0] mh [LANES];
	logic [NUM_W-1:0] num [LANES];

	// One restoring division step: one quotient bit enters the low word.
	function automatic logic [MAG_W+DIV_BITS-1:0] div_step(input logic [MAG_W-1:0] rem,
			input logic [DIV_BITS-1:0] low, input logic [MAG_W-1:0] den);
		logic [MAG_W:0] t;
		logic [MAG_W:0] d;
		t = {rem, low[DIV_BITS-1]};
		d = {1'b0, den};
		if (t >= d) begin
			return {MAG_W'(t - d), low[DIV_BITS-2:0], 1'b1};
		end else begin
			return {t[MAG_W-1:0], low[DIV_BITS-2:0], 1'b0};
		end
	endfunction

	assign last_now = (out_ctl_q.mode == MODE_SEG) || (out_k_q == 2'd2);
	assign adv = !out_valid_q || (seg_ready && last_now);
	assign pop_ready = adv;

	// Lane operands from the queue head: lanes are x0, z0, x1, z1.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			ln[l] = l[0] ? pop_item.sl[l/2].z : pop_item.sl[l/2].x;
			mh[l] = pop_item.sl[l/2].mh;
		end
		for (int l = 0; l < LANES; l++) begin
			num[l] = prod_s1[l] + NUM_W'(lc_s1[l].den >> 1);
		end
	end

	// Divider stage logic, each stage from the one before it.
	always_comb begin
		for (int j = 0; j < DIV_BITS; j++) begin
			for (int l = 0; l < LANES; l++) begin
				if (j == 0) begin
					{rem_nx[j][l], low_nx[j][l]} = div_step(rem_s2[l], low_s2[l],
						lc_s2[l].den);
				end else begin
					{rem_nx[j][l], low_nx[j][l]} = div_step(rem_sd[j-1][l],
						low_sd[j-1][l], lc_sd[j-1][l].den);
				end
			end
		end
	end

	// Valid bits of the whole pipe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_sd <= '0;
			out_valid_q <= 1'b0;
			out_k_q <= 2'd0;
		end else if (adv) begin
			valid_s1 <= pop_valid;
			valid_s2 <= valid_s1;
			valid_sd <= {valid_sd[DIV_BITS-2:0], valid_s2};
			out_valid_q <= valid_sd[DIV_BITS-1];
			out_k_q <= 2'd0;
		end else if (seg_valid && seg_ready) begin
			out_k_q <= out_k_q + 2'd1;
		end
	end

	// Payload of the pipe.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= pop_item.ctl;
			ctl_s2 <= ctl_s1;
			ctl_sd[0] <= ctl_s2;
			for (int l = 0; l < LANES; l++) begin
				prod_s1[l] <= NUM_W'(ln[l].mc) * NUM_W'(mh[l]);
				lc_s1[l] <= '{ln[l].neg, ln[l].qc, pop_item.sl[l/2].my};
				lc_s2[l] <= lc_s1[l];
				rem_s2[l] <= {1'b0, num[l][NUM_W-1:DIV_BITS]};
				low_s2[l] <= num[l][DIV_BITS-1:0];
				lc_sd[0][l] <= lc_s2[l];
			end
			for (int j = 1; j < DIV_BITS; j++) begin
				ctl_sd[j] <= ctl_sd[j-1];
				for (int l = 0; l < LANES; l++) begin
					lc_sd[j][l] <= lc_sd[j-1][l];
				end
			end
			for (int j = 0; j < DIV_BITS; j++) begin
				for (int l = 0; l < LANES; l++) begin
					rem_sd[j][l] <= rem_nx[j][l];
					low_sd[j][l] <= low_nx[j][l];
				end
			end
			out_ctl_q <= ctl_sd[DIV_BITS-1];
			for (int l = 0; l < LANES; l++) begin
				out_cr_q[l] <= lc_sd[DIV_BITS-1][l].neg ?
					lc_sd[DIV_BITS-1][l].qc - $signed(low_sd[DIV_BITS-1][l][31:0]) :
					lc_sd[DIV_BITS-1][l].qc + $signed(low_sd[DIV_BITS-1][l][31:0]);
			end
		end
	end

	// Result selection from the output register.
	point_t c0, c1, sp, ep;

	always_comb begin
		c0 = '{out_cr_q[0], out_ctl_q.h, out_cr_q[1]};
		c1 = '{out_cr_q[2], out_ctl_q.h, out_cr_q[3]};
		if (out_ctl_q.mode == MODE_SEG) begin
			sp = out_ctl_q.start_cross ? c0 : out_ctl_q.pt[0];
			ep = out_ctl_q.end_cross ? c1 : out_ctl_q.pt[1];
		end else begin
			case (out_k_q)
				2'd0: begin
					sp = out_ctl_q.pt[0];
					ep = out_ctl_q.pt[1];
				end
				2'd1: begin
					sp = out_ctl_q.pt[1];
					ep = out_ctl_q.pt[2];
				end
				default: begin
					sp = out_ctl_q.pt[2];
					ep = out_ctl_q.pt[0];
				end
			endcase
		end
		seg.out_layer = out_ctl_q.layer;
		seg.segment_kind = out_ctl_q.mode == MODE_EDGES;
		seg.start_x = sp.x;
		seg.start_y = sp.y;
		seg.start_z = sp.z;
		seg.end_x = ep.x;
		seg.end_y = ep.y;
		seg.end_z = ep.z;
		seg.last = last_now;
	end

	assign seg_valid = out_valid_q;

endmodule

`default_nettype wire

/* design/triangle_layer_slice_core.sv */
// Top level of the triangle layer slicer: configuration registers and the
// front end, queue and back end. Depends on tls_pkg, tls_front, tls_queue, tls_back.
//
//   Channel  Direction  Handshake                 Payload
//   facet    in         facet_valid/facet_ready   facet_t (layer index, three vertices)
//   seg      out        seg_valid/seg_ready       seg_t (one segment)
//   config   in         psel/penable/pwrite       APB-style, three registers on a 32-bit bus
//
// One triangle enters per cycle when the queue and back end do not stall. Between
// acceptance and the first segment lie two front stages, the queue, the crossing
// multiplier and rounding stages and the 34-stage divider, one quotient bit per stage.
// A triangle that lies in the layer holds the back end until each of its edges is taken.
// Triangles that give no segment are dropped in the front end.
// Reset is asynchronous, clears all valid bits and loads the configuration register defaults.
`default_nettype none

module triangle_layer_slice_core import tls_pkg::*; #(
	parameter int LAYER_INDEX_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire facet_t facet,
	input wire logic facet_valid,
	output logic facet_ready,
	output seg_t seg,
	output logic seg_valid,
	input wire logic seg_ready,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_t cfg_q;
	q_item_t push_item, pop_item;
	logic push_valid, push_ready, pop_valid, pop_ready;

	assign pready = 1'b1;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.y_min <= 32'sd0;
			cfg_q.layer_step <= 31'd65536;
			cfg_q.tol <= 16'd66;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_Y_MIN: cfg_q.y_min <= pwdata;
				REG_LAYER_STEP: cfg_q.layer_step <= pwdata[30:0];
				REG_TOLERANCE: cfg_q.tol <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[3:2])
			REG_Y_MIN: prdata = cfg_q.y_min;
			REG_LAYER_STEP: prdata = {1'b0, cfg_q.layer_step};
			REG_TOLERANCE: prdata = {16'd0, cfg_q.tol};
			default: prdata = 32'd0;
		endcase
	end

	tls_front #(
		.LAYER_INDEX_BITS(LAYER_INDEX_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.facet(facet),
		.facet_valid(facet_valid),
		.facet_ready(facet_ready),
		.push_item(push_item),
		.push_valid(push_valid),
		.push_ready(push_ready)
	);

	tls_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_item(push_item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.pop_item(pop_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready)
	);

	tls_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_item(pop_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.seg(seg),
		.seg_valid(seg_valid),
		.seg_ready(seg_ready)
	);

endmodule

`default_nettype wire

/* design/tls_checker.sv */
// Port-level checks for the triangle layer slicer, bound to the top level.
// Depends on tls_pkg and triangle_layer_slice_core.
`default_nettype none

module tls_checker import tls_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire seg_t seg,
	input wire logic seg_valid,
	input wire logic seg_ready
);

	// A waiting item keeps its valid.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid)
		else $error("segment valid dropped while stalled");

	// A waiting item keeps its payload.
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> $stable(seg))
		else $error("segment payload changed while stalled");

	// A plane cut is always a single result.
	a_cut_single: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg.segment_kind |-> seg.last)
		else $error("plane cut segment without last");

	// Edges of an in-layer triangle follow each other directly.
	a_edges_follow: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_ready && seg.segment_kind && !seg.last |=>
		seg_valid && seg.segment_kind)
		else $error("in-layer edge sequence broken");

endmodule

bind triangle_layer_slice_core tls_checker u_tls_checker (
	.clk(clk),
	.arst_n(arst_n),
	.seg(seg),
	.seg_valid(seg_valid),
	.seg_ready(seg_ready)
);

`default_nettype wire
